@@ rtl/core/stack_map_stream_parser_core_assert.svh @@
// assertion macros for the stack map stream parser core
// expects aclk and aresetn in the scope where the macros are used
`ifndef STACK_MAP_STREAM_PARSER_CORE_ASSERT_SVH
`define STACK_MAP_STREAM_PARSER_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SMSP_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define SMSP_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ rtl/core/smsp_pkg.sv @@
// shared types, codes and helpers of the stack map stream parser
// used by the parser, the result queue and the top level
package smsp_pkg;

    localparam int SMSP_FIFO_DEPTH = 4;

    typedef enum logic [4:0] {
        PH_MAGIC, PH_VERSION, PH_FNCOUNT, PH_NAMELEN, PH_NAME, PH_CODEOFF,
        PH_CODESIZE, PH_RECCOUNT, PH_INSTOFF, PH_FRAME, PH_SAFEPOINT,
        PH_ROOTCOUNT, PH_ROOTOFF, PH_KIND, PH_CLASS, PH_CODE, PH_RESERVED,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        EV_FUNCTION    = 3'd0,
        EV_RECORD      = 3'd1,
        EV_ROOT        = 3'd2,
        EV_DONE        = 3'd3,
        EV_BAD_MAGIC   = 3'd4,
        EV_BAD_VERSION = 3'd5,
        EV_TRUNCATED   = 3'd6
    } event_kind_t;

    localparam logic [1:0] CFG_TEXT_BASE        = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_MAGIC   = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd2;

    typedef struct packed {
        event_kind_t        event_kind;
        logic               last_of_run;
        logic [63:0]        fn_address;
        logic [31:0]        offset_word;
        logic [31:0]        size_word;
        logic [31:0]        item_count;
        logic [31:0]        safepoint_number;
        logic signed [31:0] root_offset;
        logic [7:0]         root_kind;
        logic [7:0]         register_class;
        logic [7:0]         register_code;
    } result_t;

    typedef struct packed {
        logic [63:0] text_base;
        logic [31:0] expected_magic;
        logic [31:0] expected_version;
    } cfg_t;

    // up to two results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t blank_result(input event_kind_t kind);
        result_t r;
        r = '0;
        r.event_kind = kind;
        return r;
    endfunction

endpackage

@@ rtl/core/stack_map_stream_parser_core.sv @@
// top level of the stack map stream parser: ports, registers, input stage
// depends on smsp_pkg, smsp_parser, smsp_result_fifo and the assertion header
//
// One image byte is taken per cycle on the s_ stream; s_tlast marks the final
// byte of the buffer. Each byte waits in the input register until the field
// state machine consumes it and writes zero, one or two events into a result
// queue of FIFO_DEPTH entries that feeds the m_ stream. The sustained rate is
// one byte per cycle as long as the queue has two free entries; when the m_
// side stalls, bytes are held once fewer are free. After a terminal event the
// rest of the buffer is skipped; the byte marked last always returns the
// parser to the magic word. The user is to write registers through cfg_ only
// while idle, which the block itself does not enforce: index 0 text_base,
// 1 expected_magic, 2 expected_version, others ignored. There is no clearing
// pass after reset.
`include "stack_map_stream_parser_core_assert.svh"

module stack_map_stream_parser_core
    import smsp_pkg::*;
#(
    parameter int FIFO_DEPTH = SMSP_FIFO_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // final_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // fn_address[63:0], offset_word[95:64], size_word[127:96],
    // item_count[159:128], safepoint_number[191:160], root_offset[223:192],
    // root_kind[231:224], register_class[239:232], register_code[247:240]
    output logic [247:0] m_tdata,
    output logic         m_tlast,   // last_of_run
    output logic [2:0]   m_tuser,   // event_kind[2:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int LevelW = $clog2(FIFO_DEPTH + 1);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              consume;
    push_t             push;
    phase_t            parser_phase;
    result_t           head;
    logic              fifo_room;
    logic              fifo_not_empty;
    logic [LevelW-1:0] fifo_level;

    assign cfg_ready = 1'b1;
    assign consume   = in_valid_reg && fifo_room;
    assign s_tready  = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TEXT_BASE:        cfg_reg.text_base        <= cfg_data;
                CFG_EXPECTED_MAGIC:   cfg_reg.expected_magic   <= cfg_data[31:0];
                CFG_EXPECTED_VERSION: cfg_reg.expected_version <= cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    smsp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .valid      (consume),
        .data_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .cfg        (cfg_reg),
        .push       (push),
        .phase      (parser_phase)
    );

    smsp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_tvalid && m_tready),
        .head      (head),
        .room      (fifo_room),
        .not_empty (fifo_not_empty),
        .level     (fifo_level)
    );

    assign m_tvalid = fifo_not_empty;
    assign m_tlast  = head.last_of_run;
    assign m_tuser  = head.event_kind;
    assign m_tdata  = {head.register_code, head.register_class, head.root_kind,
                       head.root_offset, head.safepoint_number, head.item_count,
                       head.size_word, head.offset_word, head.fn_address};

    `SMSP_ASSERT_NEXT(a_final_restarts, consume && in_last_reg, parser_phase == PH_MAGIC, "final byte did not restart the parser")
    `SMSP_ASSERT_NEXT(a_blocked_item_held, in_valid_reg && !consume, in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg), "blocked input item was lost")
    `SMSP_ASSERT_HOLDS(a_push_needs_item, (push.count == 2'd0) || consume, "results pushed without a consumed item")
    `SMSP_ASSERT_HOLDS(a_fifo_bound, fifo_level <= LevelW'(FIFO_DEPTH), "result queue overflow")

endmodule

@@ rtl/core/smsp_parser.sv @@
// field state machine of the stack map stream parser, one byte per cycle when valid
// depends on smsp_pkg for phases, event codes and the result struct
module smsp_parser
    import smsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       valid,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  cfg_t       cfg,
    output push_t      push,
    output phase_t     phase
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] functions_left_reg, functions_left_next;
    logic [31:0] records_left_reg, records_left_next;
    logic [31:0] roots_left_reg, roots_left_next;
    logic [31:0] name_left_reg, name_left_next;

    logic [31:0] code_offset_reg, code_offset_next;
    logic [31:0] code_size_reg, code_size_next;
    logic [31:0] inst_offset_reg, inst_offset_next;
    logic [31:0] frame_size_reg, frame_size_next;
    logic [31:0] safepoint_reg, safepoint_next;
    logic [31:0] root_offset_reg, root_offset_next;
    logic [7:0]  root_kind_reg, root_kind_next;
    logic [7:0]  reg_class_reg, reg_class_next;
    logic [7:0]  reg_code_reg, reg_code_next;

    logic [31:0] word;
    logic        gathering;
    logic        word_done;
    logic        rec_end;
    logic        func_end;
    logic        done_after;
    logic        finished;
    logic        trunc;
    logic        prim_valid;
    result_t     prim;

    assign phase = phase_reg;

    always_comb begin
        word = shift_reg;
        if (!pos_reg[2]) begin
            word[{pos_reg[1:0], 3'b000} +: 8] = data_byte;
        end
    end

    always_comb begin
        case (phase_reg) inside
            PH_MAGIC, PH_VERSION, PH_FNCOUNT, PH_NAMELEN, PH_CODEOFF, PH_CODESIZE,
            PH_RECCOUNT, PH_INSTOFF, PH_FRAME, PH_SAFEPOINT, PH_ROOTCOUNT,
            PH_ROOTOFF: gathering = 1'b1;
            default:    gathering = 1'b0;
        endcase
        word_done = (phase_reg == PH_CODEOFF) ? (pos_reg == 3'd7) : (pos_reg == 3'd3);
    end

    always_comb begin
        phase_next          = phase_reg;
        pos_next            = pos_reg;
        shift_next          = shift_reg;
        functions_left_next = functions_left_reg;
        records_left_next   = records_left_reg;
        roots_left_next     = roots_left_reg;
        name_left_next      = name_left_reg;
        code_offset_next    = code_offset_reg;
        code_size_next      = code_size_reg;
        inst_offset_next    = inst_offset_reg;
        frame_size_next     = frame_size_reg;
        safepoint_next      = safepoint_reg;
        root_offset_next    = root_offset_reg;
        root_kind_next      = root_kind_reg;
        reg_class_next      = reg_class_reg;
        reg_code_next       = reg_code_reg;
        rec_end             = 1'b0;
        func_end            = 1'b0;
        done_after          = 1'b0;
        finished            = 1'b0;
        trunc               = 1'b0;
        prim_valid          = 1'b0;
        prim                = blank_result(EV_DONE);
        push                = '0;

        if (valid) begin
            if (gathering) begin
                if (word_done) begin
                    pos_next   = 3'd0;
                    shift_next = '0;
                end else begin
                    pos_next   = pos_reg + 3'd1;
                    shift_next = word;
                end
            end

            case (phase_reg)
                PH_MAGIC: begin
                    if (word_done) begin
                        if (word != cfg.expected_magic) begin
                            prim_valid = 1'b1;
                            prim       = blank_result(EV_BAD_MAGIC);
                            finished   = 1'b1;
                        end else begin
                            phase_next = PH_VERSION;
                        end
                    end
                end
                PH_VERSION: begin
                    if (word_done) begin
                        if (word != cfg.expected_version) begin
                            prim_valid = 1'b1;
                            prim       = blank_result(EV_BAD_VERSION);
                            finished   = 1'b1;
                        end else begin
                            phase_next = PH_FNCOUNT;
                        end
                    end
                end
                PH_FNCOUNT: begin
                    if (word_done) begin
                        functions_left_next = word;
                        if (word == 32'd0) begin
                            prim_valid = 1'b1;
                            prim       = blank_result(EV_DONE);
                            finished   = 1'b1;
                        end else begin
                            phase_next = PH_NAMELEN;
                        end
                    end
                end
                PH_NAMELEN: begin
                    if (word_done) begin
                        name_left_next = word;
                        phase_next     = (word != 32'd0) ? PH_NAME : PH_CODEOFF;
                    end
                end
                PH_NAME: begin
                    name_left_next = name_left_reg - 32'd1;
                    if (name_left_reg == 32'd1) begin
                        phase_next = PH_CODEOFF;
                    end
                end
                PH_CODEOFF: begin
                    if (word_done) begin
                        code_offset_next = shift_reg;
                        phase_next       = PH_CODESIZE;
                    end
                end
                PH_CODESIZE: begin
                    if (word_done) begin
                        code_size_next = word;
                        phase_next     = PH_RECCOUNT;
                    end
                end
                PH_RECCOUNT: begin
                    if (word_done) begin
                        records_left_next     = word;
                        prim_valid            = 1'b1;
                        prim                  = blank_result(EV_FUNCTION);
                        prim.fn_address       = (cfg.text_base != 64'd0)
                            ? cfg.text_base + {32'd0, code_offset_reg} : 64'd0;
                        prim.offset_word      = code_offset_reg;
                        prim.size_word        = code_size_reg;
                        prim.item_count       = word;
                        if (word == 32'd0) begin
                            func_end = 1'b1;
                        end else begin
                            phase_next = PH_INSTOFF;
                        end
                    end
                end
                PH_INSTOFF: begin
                    if (word_done) begin
                        inst_offset_next = word;
                        phase_next       = PH_FRAME;
                    end
                end
                PH_FRAME: begin
                    if (word_done) begin
                        frame_size_next = word;
                        phase_next      = PH_SAFEPOINT;
                    end
                end
                PH_SAFEPOINT: begin
                    if (word_done) begin
                        safepoint_next = word;
                        phase_next     = PH_ROOTCOUNT;
                    end
                end
                PH_ROOTCOUNT: begin
                    if (word_done) begin
                        roots_left_next       = word;
                        prim_valid            = 1'b1;
                        prim                  = blank_result(EV_RECORD);
                        prim.offset_word      = inst_offset_reg;
                        prim.size_word        = frame_size_reg;
                        prim.item_count       = word;
                        prim.safepoint_number = safepoint_reg;
                        if (word == 32'd0) begin
                            rec_end = 1'b1;
                        end else begin
                            phase_next = PH_ROOTOFF;
                        end
                    end
                end
                PH_ROOTOFF: begin
                    if (word_done) begin
                        root_offset_next = word;
                        phase_next       = PH_KIND;
                    end
                end
                PH_KIND: begin
                    root_kind_next = data_byte;
                    phase_next     = PH_CLASS;
                end
                PH_CLASS: begin
                    reg_class_next = data_byte;
                    phase_next     = PH_CODE;
                end
                PH_CODE: begin
                    reg_code_next = data_byte;
                    phase_next    = PH_RESERVED;
                end
                PH_RESERVED: begin
                    prim_valid          = 1'b1;
                    prim                = blank_result(EV_ROOT);
                    prim.root_offset    = root_offset_reg;
                    prim.root_kind      = root_kind_reg;
                    prim.register_class = reg_class_reg;
                    prim.register_code  = reg_code_reg;
                    roots_left_next     = roots_left_reg - 32'd1;
                    if (roots_left_reg == 32'd1) begin
                        rec_end = 1'b1;
                    end else begin
                        phase_next = PH_ROOTOFF;
                    end
                end
                default: begin
                end
            endcase

            // closing of a record can close its function and the image
            if (rec_end) begin
                records_left_next = records_left_reg - 32'd1;
                if (records_left_reg == 32'd1) begin
                    func_end = 1'b1;
                end else begin
                    phase_next = PH_INSTOFF;
                end
            end
            if (func_end) begin
                functions_left_next = functions_left_reg - 32'd1;
                if (functions_left_reg == 32'd1) begin
                    done_after = 1'b1;
                    finished   = 1'b1;
                end else begin
                    phase_next = PH_NAMELEN;
                end
            end

            if (!finished && final_byte) begin
                trunc = (phase_reg != PH_SKIP);
            end
            if (final_byte) begin
                phase_next          = PH_MAGIC;
                pos_next            = 3'd0;
                shift_next          = '0;
                functions_left_next = '0;
                records_left_next   = '0;
                roots_left_next     = '0;
                name_left_next      = '0;
            end else if (finished) begin
                phase_next = PH_SKIP;
            end

            if (prim_valid) begin
                push.first = prim;
                if (done_after) begin
                    push.second = blank_result(EV_DONE);
                    push.count  = 2'd2;
                end else if (trunc) begin
                    push.second = blank_result(EV_TRUNCATED);
                    push.count  = 2'd2;
                end else begin
                    push.count = 2'd1;
                end
            end else if (trunc) begin
                push.first = blank_result(EV_TRUNCATED);
                push.count = 2'd1;
            end
            if (push.count == 2'd2) begin
                push.second.last_of_run = 1'b1;
            end else begin
                push.first.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_MAGIC;
            pos_reg            <= 3'd0;
            shift_reg          <= '0;
            functions_left_reg <= '0;
            records_left_reg   <= '0;
            roots_left_reg     <= '0;
            name_left_reg      <= '0;
        end else begin
            phase_reg          <= phase_next;
            pos_reg            <= pos_next;
            shift_reg          <= shift_next;
            functions_left_reg <= functions_left_next;
            records_left_reg   <= records_left_next;
            roots_left_reg     <= roots_left_next;
            name_left_reg      <= name_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_offset_reg <= code_offset_next;
        code_size_reg   <= code_size_next;
        inst_offset_reg <= inst_offset_next;
        frame_size_reg  <= frame_size_next;
        safepoint_reg   <= safepoint_next;
        root_offset_reg <= root_offset_next;
        root_kind_reg   <= root_kind_next;
        reg_class_reg   <= reg_class_next;
        reg_code_reg    <= reg_code_next;
    end

endmodule

@@ rtl/core/smsp_result_fifo.sv @@
// result queue of the stack map stream parser, takes up to two items a cycle
// depends on smsp_pkg for the result and push structs
module smsp_result_fifo
    import smsp_pkg::*;
#(
    parameter int DEPTH = SMSP_FIFO_DEPTH,
    localparam int LevelW = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  push_t             push,
    input  logic              pop,
    output result_t           head,
    output logic              room,
    output logic              not_empty,
    output logic [LevelW-1:0] level
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    result_t           mem_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PtrW-1:0]   wr_ptr_plus1;
    logic [LevelW-1:0] level_reg, level_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign head         = mem_reg[rd_ptr_reg];
    assign not_empty    = (level_reg != '0);
    assign room         = (level_reg <= LevelW'(DEPTH - 2));
    assign level        = level_reg;

    always_comb begin
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + LevelW'(push.count) - LevelW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule
